[src/spnc_pkg.sv]
package spnc_pkg;

    localparam int VID_W      = 5;
    localparam int WEIGHT_W   = 16;
    localparam int DIST_W     = 32;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int VC_RESET   = 32;

    localparam logic signed [DIST_W-1:0] DIST_INF = 32'sd100000000;
    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

    // result kinds
    localparam logic KIND_CYCLE = 1'b0;
    localparam logic KIND_DIST  = 1'b1;

    typedef struct packed {
        logic [VID_W-1:0]           from_v;
        logic [VID_W-1:0]           to_v;
        logic signed [WEIGHT_W-1:0] weight;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

    typedef enum logic [10:0] {
        S_LOAD = 11'b000_0000_0001,
        S_INIT = 11'b000_0000_0010,
        S_EA   = 11'b000_0000_0100,
        S_EB   = 11'b000_0000_1000,
        S_DU   = 11'b000_0001_0000,
        S_DV   = 11'b000_0010_0000,
        S_WALK = 11'b000_0100_0000,
        S_COLL = 11'b000_1000_0000,
        S_COUT = 11'b001_0000_0000,
        S_DRD  = 11'b010_0000_0000,
        S_DLD  = 11'b100_0000_0000
    } t_state;

endpackage

[src/spnc_ram.sv]
module spnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/shortest_path_neg_cycle_finder_core.sv]
// channel   | direction | handshake                    | word
// ----------+-----------+------------------------------+-------------------------------------
// cfg       | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
// edge in   | in        | i_in_valid / o_in_stall      | from, to, weight, last_edge
// result    | out       | o_out_valid / i_out_stall    | kind, vertex, distance, cycle, last
//
// one edge loads per cycle in S_LOAD; the edge with last_edge set starts a run and the input
// stalls until the run's final result sits in the output register.
// run: setup of the n distances, then n passes over the stored edges, each in-range edge
// stepping S_EA, S_EB, S_DU, S_DV and a skipped one S_EA, S_EB, as one read port of the
// distance RAM feeds one shared adder/compare; if the last pass relaxed, n parent-walk steps
// and up to n cycle vertices collected and sent, then distances (n = effective vertex_count).
// reset is synchronous active low, clears control state only; no clearing pass.
module shortest_path_neg_cycle_finder_core #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spnc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spnc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [spnc_pkg::VID_W-1:0]          i_from_vertex,
    input  logic [spnc_pkg::VID_W-1:0]          i_to_vertex,
    input  logic signed [spnc_pkg::WEIGHT_W-1:0] i_edge_weight,
    input  logic                                i_last_edge,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_item_kind,
    output logic [spnc_pkg::VID_W-1:0]          o_vertex_id,
    output logic signed [spnc_pkg::DIST_W-1:0]  o_distance,
    output logic                                o_cycle_found,
    output logic                                o_last_result
);
    import spnc_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TW = $clog2(MAX_EDGES + 1);

    t_state r_state;

    logic [CFG_DATA_W-1:0] r_vc;
    logic [VID_W-1:0]      r_src;

    logic [TW-1:0] r_total;
    logic [EW-1:0] r_e;
    logic [VW-1:0] r_pass;
    logic [VW-1:0] r_vidx;
    t_edge         r_edge;
    logic signed [DIST_W-1:0] r_du;
    logic          r_any;
    logic [VW-1:0] r_last;

    logic [VW-1:0]           r_parent [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_pvalid;
    logic [VW-1:0]           r_clist  [MAX_VERTICES];
    logic [NW-1:0]           r_ccnt;
    logic [VW-1:0]           r_cidx;
    logic [VW-1:0]           r_y;
    logic [VW-1:0]           r_cur;
    logic [VW-1:0]           r_wcnt;

    logic                    r_o_valid;
    logic                    r_o_kind;
    logic [VID_W-1:0]        r_o_vid;
    logic signed [DIST_W-1:0] r_o_dist;
    logic                    r_o_cyc;
    logic                    r_o_last;

    logic [NW-1:0] w_n;
    logic          w_src_ok;
    logic          w_in_acc;
    logic          w_free;
    logic          w_vlast;
    logic          w_edge_last;
    logic          w_pass_last;
    logic          w_walk_last;

    logic          e_we;
    t_edge         e_wdata;
    t_edge         e_rdata;
    logic [DIST_W-1:0] d_rdata;
    logic          d_we;
    logic [VW-1:0] d_waddr;
    logic [VW-1:0] d_raddr;
    logic [DIST_W-1:0] d_wdata;

    logic              w_range_ok;
    logic signed [DIST_W:0] w_sum;
    logic              w_less;
    logic signed [DIST_W-1:0] w_sat;
    logic              w_relax;
    logic              w_any_now;
    logic [VW-1:0]     w_last_now;

    logic [VW-1:0]     w_paddr;
    logic [VW-1:0]     w_pp;
    logic              w_pv;
    logic [VW-1:0]     w_ynext;

    // effective vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vc == '0) begin
            w_n = NW'(1);
        end else if (r_vc > CFG_DATA_W'(MAX_VERTICES)) begin
            w_n = NW'(MAX_VERTICES);
        end else begin
            w_n = NW'(r_vc);
        end
    end

    assign w_src_ok    = CFG_DATA_W'(r_src) < CFG_DATA_W'(w_n);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_free      = !r_o_valid || !i_out_stall;
    assign w_vlast     = (NW'(r_vidx) + NW'(1)) == w_n;
    assign w_edge_last = (TW'(r_e) + TW'(1)) == r_total;
    assign w_pass_last = (NW'(r_pass) + NW'(1)) == w_n;
    assign w_walk_last = (NW'(r_wcnt) + NW'(1)) == w_n;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_LOAD);

    // edge store
    assign e_we    = w_in_acc && (r_total < TW'(MAX_EDGES));
    assign e_wdata = '{from_v: i_from_vertex, to_v: i_to_vertex, weight: i_edge_weight};

    spnc_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_total[EW-1:0]),
        .i_wdata (e_wdata),
        .i_raddr (r_e),
        .o_rdata (e_rdata)
    );

    // shared add / compare / saturate unit
    assign w_range_ok = (CFG_DATA_W'(e_rdata.from_v) < CFG_DATA_W'(w_n))
                     && (CFG_DATA_W'(e_rdata.to_v) < CFG_DATA_W'(w_n));
    assign w_sum  = {r_du[DIST_W-1], r_du}
                  + {{(DIST_W + 1 - WEIGHT_W){r_edge.weight[WEIGHT_W-1]}}, r_edge.weight};
    assign w_less = w_sum < $signed({d_rdata[DIST_W-1], d_rdata});

    always_comb begin
        if (w_sum[DIST_W] != w_sum[DIST_W-1]) begin
            w_sat = w_sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
            w_sat = w_sum[DIST_W-1:0];
        end
    end

    assign w_relax    = (r_state == S_DV) && w_less;
    assign w_any_now  = r_any || w_relax;
    assign w_last_now = w_relax ? r_edge.to_v[VW-1:0] : r_last;

    // distance table ports
    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_vidx;
        d_wdata = DIST_INF;
        if (r_state == S_INIT) begin
            d_we    = 1'b1;
            d_wdata = (w_src_ok && (VID_W'(r_vidx) == r_src)) ? '0 : DIST_INF;
        end else if (w_relax) begin
            d_we    = 1'b1;
            d_waddr = r_edge.to_v[VW-1:0];
            d_wdata = w_sat;
        end
    end

    always_comb begin
        priority if (r_state == S_EB) begin
            d_raddr = e_rdata.from_v[VW-1:0];
        end else if (r_state == S_DU) begin
            d_raddr = r_edge.to_v[VW-1:0];
        end else begin
            d_raddr = r_vidx;
        end
    end

    spnc_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // parent lookup, one address per cycle
    assign w_paddr = (r_state == S_COLL) ? r_cur : r_y;
    assign w_pp    = r_parent[w_paddr];
    assign w_pv    = r_pvalid[w_paddr];
    assign w_ynext = w_pv ? w_pp : r_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc  <= CFG_DATA_W'(VC_RESET);
            r_src <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT:  r_vc  <= i_cfg_data;
                CFG_SOURCE_VERTEX: r_src <= i_cfg_data[VID_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_total   <= '0;
            r_any     <= 1'b0;
            r_o_valid <= 1'b0;
            r_pvalid  <= '0;
        end else begin
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_total < TW'(MAX_EDGES)) begin
                            r_total <= r_total + TW'(1);
                        end
                        if (i_last_edge) begin
                            r_vidx   <= '0;
                            r_pvalid <= '0;
                            r_state  <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (w_vlast) begin
                        r_e     <= '0;
                        r_pass  <= '0;
                        r_any   <= 1'b0;
                        r_state <= S_EA;
                    end else begin
                        r_vidx <= r_vidx + VW'(1);
                    end
                end
                S_EA: begin
                    r_state <= S_EB;
                end
                S_EB, S_DV: begin
                    if ((r_state == S_EB) && w_range_ok) begin
                        r_edge  <= e_rdata;
                        r_state <= S_DU;
                    end else begin
                        if (w_relax) begin
                            r_parent[r_edge.to_v[VW-1:0]] <= r_edge.from_v[VW-1:0];
                            r_pvalid[r_edge.to_v[VW-1:0]] <= 1'b1;
                            r_last <= r_edge.to_v[VW-1:0];
                            r_any  <= 1'b1;
                        end
                        // step to the next edge, pass, or finish the run
                        if (w_edge_last) begin
                            r_e <= '0;
                            if (w_pass_last) begin
                                r_total <= '0;
                                if (w_any_now) begin
                                    r_y     <= w_last_now;
                                    r_wcnt  <= '0;
                                    r_state <= S_WALK;
                                end else begin
                                    r_vidx  <= '0;
                                    r_state <= S_DRD;
                                end
                            end else begin
                                r_pass  <= r_pass + VW'(1);
                                r_any   <= 1'b0;
                                r_state <= S_EA;
                            end
                        end else begin
                            r_e     <= r_e + EW'(1);
                            r_state <= S_EA;
                        end
                    end
                end
                S_DU: begin
                    r_du    <= d_rdata;
                    r_state <= S_DV;
                end
                S_WALK: begin
                    r_y    <= w_ynext;
                    r_wcnt <= r_wcnt + VW'(1);
                    if (w_walk_last) begin
                        r_cur      <= w_ynext;
                        r_clist[0] <= w_ynext;
                        r_ccnt     <= NW'(1);
                        r_state    <= S_COLL;
                    end
                end
                S_COLL: begin
                    if ((r_ccnt == w_n) || !w_pv || (w_pp == r_y)) begin
                        r_cidx  <= VW'(r_ccnt - NW'(1));
                        r_state <= S_COUT;
                    end else begin
                        r_cur                   <= w_pp;
                        r_clist[r_ccnt[VW-1:0]] <= w_pp;
                        r_ccnt                  <= r_ccnt + NW'(1);
                    end
                end
                S_COUT: begin
                    if (w_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= KIND_CYCLE;
                        r_o_vid   <= VID_W'(r_clist[r_cidx]);
                        r_o_dist  <= '0;
                        r_o_cyc   <= 1'b1;
                        r_o_last  <= 1'b0;
                        if (r_cidx == '0) begin
                            r_vidx  <= '0;
                            r_state <= S_DRD;
                        end else begin
                            r_cidx <= r_cidx - VW'(1);
                        end
                    end
                end
                S_DRD: begin
                    r_state <= S_DLD;
                end
                S_DLD: begin
                    if (w_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= KIND_DIST;
                        r_o_vid   <= VID_W'(r_vidx);
                        r_o_dist  <= d_rdata;
                        r_o_cyc   <= r_any;
                        r_o_last  <= w_vlast;
                        if (w_vlast) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_vidx  <= r_vidx + VW'(1);
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_item_kind   = r_o_kind;
    assign o_vertex_id   = r_o_vid;
    assign o_distance    = r_o_dist;
    assign o_cycle_found = r_o_cyc;
    assign o_last_result = r_o_last;

endmodule

[src/spnc_checker.sv]
module spnc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 i_last_edge,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic                                 o_item_kind,
    input logic [spnc_pkg::VID_W-1:0]           o_vertex_id,
    input logic signed [spnc_pkg::DIST_W-1:0]   o_distance,
    input logic                                 o_cycle_found,
    input logic                                 o_last_result
);
    import spnc_pkg::*;

    // a final edge starts a run, so the input must stall next
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_edge |=> o_in_stall)
        else $error("input not stalled after final edge");

    // a non-final edge leaves the block ready for the next word
    a_load_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_last_edge |=> !o_in_stall)
        else $error("input stalled after non-final edge");

    // a cycle vertex carries zero distance and the cycle flag
    a_cycle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_item_kind == KIND_CYCLE) |-> (o_distance == '0) && o_cycle_found)
        else $error("malformed cycle word");

    // the run closes on a distance word
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_result |-> (o_item_kind == KIND_DIST))
        else $error("final word is not a distance");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_vertex_id)
            && $stable(o_distance) && $stable(o_item_kind) && $stable(o_last_result))
        else $error("stalled result word changed");

endmodule

bind shortest_path_neg_cycle_finder_core spnc_checker u_spnc_checker (.*);
